>>> rtl/lues_pkg.sv
// lues_pkg: shared types and constants for the line upper envelope sweep
// used by lues_div and line_upper_envelope_sweep
`timescale 1ns / 1ps
package lues_pkg;
    localparam int SlopeW = 32;
    localparam int TagW   = 16;
    localparam int BoundW = 48;
    localparam int NumW   = 49;
    localparam logic signed [BoundW-1:0] BoundMax = {1'b0, {(BoundW-1){1'b1}}};
    localparam logic signed [BoundW-1:0] BoundMin = {1'b1, {(BoundW-1){1'b0}}};

    typedef struct packed {
        logic              start;
        logic signed [NumW-1:0] num;
        logic signed [SlopeW:0] den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [BoundW-1:0] quot;
    } div_rsp_t;
endpackage

>>> rtl/lues_div.sv
// lues_div: restoring signed divider, one quotient bit per cycle, saturated to 48 bits
// depends on lues_pkg
`timescale 1ns / 1ps
module lues_div
    import lues_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0]   quo_reg;
    logic [SlopeW:0]   rem_reg;
    logic [SlopeW:0]   dv_reg;
    logic              neg_reg;
    logic [CntW-1:0]   cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [SlopeW+1:0] trial;
    logic [SlopeW+1:0] shifted;
    logic signed [NumW:0] sq;
    assign shifted = {rem_reg, quo_reg[NumW-1]};
    assign trial   = shifted - {1'b0, dv_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                quo_reg  <= req.num[NumW-1] ? NumW'(-req.num) : req.num;
                dv_reg   <= req.den[SlopeW] ? (SlopeW+1)'(-req.den) : req.den;
                neg_reg  <= req.num[NumW-1] ^ req.den[SlopeW];
                rem_reg  <= '0;
                cnt_reg  <= CntW'(NumW);
            end else if (busy_reg) begin
                if (!trial[SlopeW+1]) begin
                    rem_reg <= trial[SlopeW:0];
                    quo_reg <= {quo_reg[NumW-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted[SlopeW:0];
                    quo_reg <= {quo_reg[NumW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // magnitude up to 2^48 so sign plus one bit covers it
    assign sq = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    always_comb begin
        rsp.done = done_reg;
        if (sq > $signed({{2{BoundMax[BoundW-1]}}, BoundMax})) rsp.quot = BoundMax;
        else if (sq < $signed({{2{BoundMin[BoundW-1]}}, BoundMin})) rsp.quot = BoundMin;
        else rsp.quot = sq[BoundW-1:0];
    end
endmodule

>>> rtl/line_upper_envelope_sweep.sv
// line_upper_envelope_sweep: top level, line store, insertion sort and hull stack
// depends on lues_pkg and lues_div
//
// channel  dir  fields (tdata low bit up)                           tuser / tlast
// s_axis   in   line_slope[31:0] line_offset[63:32] line_tag[79:64]  tlast=last_line
// m_axis   out  env_slope, env_offset, env_tag, left_bound [127:80]  tuser={dropped,unb}
//                                                                     tlast=last_result
// loading takes one line per cycle while s_tvalid; after the marked line the block
// sorts by insertion (n^2/2 element shifts worst case), then sweeps the sorted lines
// with a breakpoint division in lues_div against the hull top, then emits one word at
// a time, holding each in S_EOUT until m_tready takes it.
// reset is synchronous; input is not taken during sort, sweep and emit.
`timescale 1ns / 1ps
module line_upper_envelope_sweep
    import lues_pkg::*;
#(
    parameter int MAX_LINES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,  // line_slope, line_offset, line_tag
    input  logic         s_tlast,  // last_line
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // env_slope, env_offset, env_tag, left_bound
    output logic [1:0]   m_tuser,  // left_unbounded, lines_dropped
    output logic         m_tlast   // last_result
);
    localparam int IW = $clog2(MAX_LINES);
    localparam int CW = $clog2(MAX_LINES + 1);

    typedef enum logic [4:0] {
        S_LOAD, S_SK, S_SR0, S_SR1, S_SW, S_SW2,
        S_WK, S_WRD, S_WCHK, S_WT, S_WTD, S_WDIV, S_WPUSH,
        S_EK, S_ERD, S_EOUT
    } state_t;

    // line store
    logic [SlopeW-1:0] slope_mem [MAX_LINES];
    logic [SlopeW-1:0] offset_mem [MAX_LINES];
    logic [TagW-1:0]   tag_mem [MAX_LINES];
    // sorted order, hull index and bound stacks
    logic [IW-1:0]     order_mem [MAX_LINES];
    logic [IW-1:0]     hidx_mem [MAX_LINES];
    logic [BoundW:0]   hbnd_mem [MAX_LINES];

    state_t state_reg;
    logic [CW-1:0] cnt_reg, k_reg, j_reg, dep_reg;
    logic          ovf_reg;
    logic signed [SlopeW-1:0] cs_reg, co_reg;  // current line
    logic [IW-1:0] ci_reg;
    logic [BoundW:0] pb_reg;
    logic [BoundW-1:0] q_reg;
    logic [IW-1:0] oprev_reg;

    // registered reads
    logic [IW-1:0]     ord_addr, hidx_addr, ln_addr;
    logic [IW-1:0]     ord_rd, hidx_rd;
    logic [BoundW:0]   hbnd_rd;
    logic [SlopeW-1:0] slope_rd, offset_rd;
    logic [TagW-1:0]   tag_rd;

    logic ord_we, h_we;
    logic [IW-1:0] ord_wa, ord_wd, h_wa;
    logic [BoundW:0] h_bd;

    div_req_t dreq;
    div_rsp_t drsp;
    lues_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    logic s_fire, m_fire;
    assign s_tready = (state_reg == S_LOAD);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (s_fire && cnt_reg != CW'(MAX_LINES)) begin
            slope_mem[cnt_reg[IW-1:0]]  <= s_tdata[31:0];
            offset_mem[cnt_reg[IW-1:0]] <= s_tdata[63:32];
            tag_mem[cnt_reg[IW-1:0]]    <= s_tdata[79:64];
        end
        if (ord_we) order_mem[ord_wa] <= ord_wd;
        if (h_we) begin
            hidx_mem[h_wa] <= ci_reg;
            hbnd_mem[h_wa] <= h_bd;
        end
        ord_rd    <= order_mem[ord_addr];
        hidx_rd   <= hidx_mem[hidx_addr];
        hbnd_rd   <= hbnd_mem[hidx_addr];
        slope_rd  <= slope_mem[ln_addr];
        offset_rd <= offset_mem[ln_addr];
        tag_rd    <= tag_mem[ln_addr];
    end

    // operands taken straight from the top line read, valid while in S_WTD
    logic signed [SlopeW:0] den_w;
    logic signed [SlopeW:0] odiff_w;
    logic signed [NumW-1:0] num_w;
    assign den_w   = {slope_rd[SlopeW-1], slope_rd} - {cs_reg[SlopeW-1], cs_reg};
    assign odiff_w = {co_reg[SlopeW-1], co_reg} - {offset_rd[SlopeW-1], offset_rd};
    assign num_w   = {odiff_w, 16'b0};

    always_comb begin
        ord_addr  = j_reg[IW-1:0] - 1'b1;
        hidx_addr = dep_reg[IW-1:0] - 1'b1;
        ln_addr   = k_reg[IW-1:0];
        ord_we = 1'b0; ord_wa = j_reg[IW-1:0]; ord_wd = k_reg[IW-1:0];
        h_we = 1'b0; h_wa = dep_reg[IW-1:0];
        h_bd = (dep_reg == '0) ? {1'b1, {BoundW{1'b0}}} : {1'b0, q_reg};
        dreq.start = 1'b0; dreq.num = num_w; dreq.den = den_w;
        case (state_reg)
            S_SK:    ord_addr = k_reg[IW-1:0] - 1'b1;
            S_SR0:   ln_addr = ord_rd;
            S_SW:    begin
                ord_we = 1'b1; ord_wd = oprev_reg;
                ord_addr = j_reg[IW-1:0] - IW'(2);
            end
            S_SW2:   ord_we = 1'b1;
            S_WK:    ord_addr = k_reg[IW-1:0];
            S_WRD:   ln_addr = ord_rd;
            S_WT:    ln_addr = hidx_rd;
            S_WTD:   begin dreq.start = 1'b1; ln_addr = ci_reg; end
            S_WDIV:  ln_addr = ci_reg;
            S_WPUSH: h_we = 1'b1;
            S_EK:    hidx_addr = k_reg[IW-1:0];
            S_ERD:   begin ln_addr = hidx_rd; hidx_addr = k_reg[IW-1:0]; end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            cnt_reg <= '0; ovf_reg <= 1'b0; dep_reg <= '0;
            m_tvalid <= 1'b0; k_reg <= '0; j_reg <= '0;
        end else begin
            case (state_reg)
                S_LOAD: if (s_fire) begin
                    if (cnt_reg != CW'(MAX_LINES)) cnt_reg <= cnt_reg + 1'b1;
                    else ovf_reg <= 1'b1;
                    if (s_tlast) begin
                        k_reg <= '0; state_reg <= S_SK;
                    end
                end
                // insertion: current line k, hole at j
                S_SK: if (k_reg == cnt_reg) begin
                    k_reg <= '0; dep_reg <= '0; state_reg <= S_WK;
                end else begin
                    j_reg <= k_reg; state_reg <= S_SR0;
                end
                S_SR0: begin
                    // slope_rd now holds line k (read issued at S_SK or S_SW)
                    cs_reg <= slope_rd;
                    if (j_reg == '0) state_reg <= S_SW2;
                    else state_reg <= S_SR1;
                    oprev_reg <= ord_rd;
                end
                S_SR1: begin
                    if ($signed(slope_rd) > cs_reg) state_reg <= S_SW;
                    else state_reg <= S_SW2;
                end
                S_SW: begin
                    j_reg <= j_reg - 1'b1;
                    if (j_reg == CW'(1)) state_reg <= S_SW2;
                    else state_reg <= S_SR0;
                end
                S_SW2: begin
                    k_reg <= k_reg + 1'b1; state_reg <= S_SK;
                end
                // sweep
                S_WK: if (k_reg == cnt_reg) begin
                    k_reg <= '0; state_reg <= S_EK;
                end else state_reg <= S_WRD;
                S_WRD: begin
                    ci_reg <= ord_rd; state_reg <= S_WCHK;
                end
                S_WCHK: begin
                    cs_reg <= slope_rd; co_reg <= offset_rd;
                    state_reg <= (dep_reg == '0) ? S_WPUSH : S_WT;
                end
                S_WT: begin
                    pb_reg <= hbnd_rd; state_reg <= S_WTD;
                end
                S_WTD: begin
                    state_reg <= S_WDIV;
                    if ($signed(slope_rd) == cs_reg) begin
                        state_reg <= S_WCHK;
                        if (co_reg <= $signed(offset_rd)) begin
                            k_reg <= k_reg + 1'b1; state_reg <= S_WK;
                        end else dep_reg <= dep_reg - 1'b1;
                    end
                end
                S_WDIV: if (drsp.done) begin
                    q_reg <= drsp.quot;
                    if (pb_reg[BoundW] || $signed(drsp.quot) > $signed(pb_reg[BoundW-1:0]))
                        state_reg <= S_WPUSH;
                    else begin
                        dep_reg <= dep_reg - 1'b1;
                        state_reg <= S_WCHK;
                    end
                end
                S_WPUSH: begin
                    dep_reg <= dep_reg + 1'b1;
                    k_reg <= k_reg + 1'b1; state_reg <= S_WK;
                end
                // emit
                S_EK: state_reg <= S_ERD;
                S_ERD: state_reg <= S_EOUT;
                S_EOUT: begin
                    if (!m_tvalid) begin
                        m_tvalid <= 1'b1;
                        m_tdata  <= {hbnd_rd[BoundW-1:0], tag_rd, offset_rd, slope_rd};
                        m_tuser  <= {ovf_reg, hbnd_rd[BoundW]};
                        m_tlast  <= (k_reg + 1'b1 == dep_reg);
                    end else if (m_fire) begin
                        m_tvalid <= 1'b0;
                        if (m_tlast) begin
                            cnt_reg <= '0; ovf_reg <= 1'b0; dep_reg <= '0;
                            state_reg <= S_LOAD;
                        end else begin
                            k_reg <= k_reg + 1'b1; state_reg <= S_EK;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end
endmodule

>>> dv/tb_top.sv
// tb_top: self-checking testbench for line_upper_envelope_sweep
// streams line sets into the block and checks each envelope word against an in-bench predictor
// depends on the line_upper_envelope_sweep rtl
`timescale 1ns / 1ps
module tb_top;

    localparam int Depth      = 64;
    localparam int IdleLimit  = 200000;
    localparam longint BndHi  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint BndLo  = -BndHi - 1;

    typedef struct {
        logic [31:0] slope;
        logic [31:0] offset;
        logic [15:0] tag;
    } line_t;

    typedef struct {
        logic [31:0] slope;
        logic [31:0] offset;
        logic [15:0] tag;
        logic [47:0] bound;
        logic        unb;
        logic        lst;
        logic        dropped;
    } env_word_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;  // line_slope, line_offset, line_tag
    logic         s_tlast;  // last_line
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;  // env_slope, env_offset, env_tag, left_bound
    logic [1:0]   m_tuser;  // left_unbounded, lines_dropped
    logic         m_tlast;  // last_result

    line_t     loaded_lines[$];
    bit        set_overflow;
    env_word_t envelope_due[$];

    int  errors;
    int  lines_sent;
    int  sets_swept;
    int  words_seen;
    int  overflow_sets;
    int  idle_cycles;
    int  hold_cycles;
    bit  quiet;

    line_upper_envelope_sweep #(.MAX_LINES(Depth)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // breakpoint of the new line against the previous one, truncated and saturated
    function automatic longint cross_point(longint o_new, longint s_new, longint o_prev,
                                           longint s_prev);
        longint q;
        q = ((o_new - o_prev) * 65536) / (s_prev - s_new);
        if (q > BndHi) q = BndHi;
        if (q < BndLo) q = BndLo;
        return q;
    endfunction

    // stable slope sort, then stack sweep into the upper envelope
    task automatic sweep_envelope();
        int     order[$];
        int     stk_idx[Depth];
        longint stk_bnd[Depth];
        bit     stk_open[Depth];
        int     top;
        int     j;
        int     i;
        longint s;
        longint o;
        longint q;
        bit     discard;
        env_word_t w;
        for (int k = 0; k < loaded_lines.size(); k++) begin
            j = order.size();
            while (j > 0 && $signed(loaded_lines[order[j-1]].slope) >
                            $signed(loaded_lines[k].slope)) j--;
            order.insert(j, k);
        end
        top = 0;
        foreach (order[k]) begin
            i = order[k];
            s = $signed(loaded_lines[i].slope);
            o = $signed(loaded_lines[i].offset);
            q = 0;
            discard = 0;
            if (top > 0 && $signed(loaded_lines[stk_idx[top-1]].slope) == s) begin
                if (o <= $signed(loaded_lines[stk_idx[top-1]].offset)) discard = 1;
                else top--;
            end
            while (!discard && top > 0) begin
                q = cross_point(o, s, $signed(loaded_lines[stk_idx[top-1]].offset),
                                $signed(loaded_lines[stk_idx[top-1]].slope));
                if (stk_open[top-1] || q > stk_bnd[top-1]) break;
                top--;
            end
            if (!discard) begin
                stk_idx[top]  = i;
                stk_open[top] = (top == 0);
                stk_bnd[top]  = (top == 0) ? 0 : q;
                top++;
            end
        end
        for (int k = 0; k < top; k++) begin
            w.slope   = loaded_lines[stk_idx[k]].slope;
            w.offset  = loaded_lines[stk_idx[k]].offset;
            w.tag     = loaded_lines[stk_idx[k]].tag;
            w.bound   = stk_open[k] ? 48'd0 : stk_bnd[k][47:0];
            w.unb     = stk_open[k];
            w.lst     = (k == top - 1);
            w.dropped = set_overflow;
            envelope_due.insert(envelope_due.size(), w);
        end
        if (set_overflow) overflow_sets++;
        sets_swept++;
        loaded_lines.delete();
        set_overflow = 0;
    endtask

    task automatic send_line(input logic [31:0] sl, input logic [31:0] of,
                             input logic [15:0] tg, input bit lst);
        line_t ln;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tdata  = {tg, of, sl};
        s_tlast  = lst;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        lines_sent++;
        ln.slope = sl; ln.offset = of; ln.tag = tg;
        if (loaded_lines.size() < Depth) loaded_lines.insert(loaded_lines.size(), ln);
        else set_overflow = 1;
        if (lst) sweep_envelope();
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (envelope_due.size() != 0) @(negedge aclk);
    endtask

    // mix of full-range, small, extreme and pooled values so equal slopes occur
    function automatic logic [31:0] pick_q16(input int pool);
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 16)) - 8) <<< 16;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: return 32'($signed($urandom_range(0, pool)) - pool / 2) <<< 14;
            default: return 32'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic send_set(input int n);
        for (int k = 0; k < n; k++)
            send_line(pick_q16(6), pick_q16(200), 16'($urandom), k == n - 1);
    endtask

    task automatic test_directed();
        send_line(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1);
        // equal slope and offset keeps the earlier line
        send_line(32'h0001_0000, 32'h0000_0005, 16'h0001, 0);
        send_line(32'h0001_0000, 32'h0000_0005, 16'h0002, 1);
        // equal slope, greater later offset replaces
        send_line(32'h8000_0000, 32'h0000_0000, 16'h0000, 0);
        send_line(32'h8000_0000, 32'h7FFF_FFFF, 16'h0003, 1);
        // three lines through one point: middle popped on equal breakpoint
        send_line(32'hFFFF_0000, 32'h0, 16'h0010, 0);
        send_line(32'h0000_0000, 32'h0, 16'h0011, 0);
        send_line(32'h0001_0000, 32'h0, 16'h0012, 1);
        // breakpoint saturates low and high, loaded out of slope order
        send_line(32'h0000_0001, 32'h7FFF_FFFF, 16'h0020, 0);
        send_line(32'h0000_0000, 32'h8000_0000, 16'h0021, 0);
        send_line(32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'h0022, 1);
        send_line(32'h0000_0000, 32'h7FFF_FFFF, 16'h0030, 0);
        send_line(32'h0000_0001, 32'h8000_0000, 16'h0031, 0);
        send_line(32'h8000_0000, 32'h8000_0000, 16'hAAAA, 0);
        send_line(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h5555, 1);
    endtask

    task automatic test_overflow();
        // more lines than the store holds, marked line dropped as well
        send_set(Depth + 2);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_cycles = 800;
        send_set(12);
        send_set(12);
        send_set(3);
        wait_drained();
    endtask

    task automatic test_random();
        while (lines_sent < 440) begin
            if ($urandom_range(0, 9) == 0) send_set($urandom_range(20, 40));
            else send_set($urandom_range(1, 10));
        end
    endtask

    task automatic test_no_idle();
        quiet = 1;
        repeat (6) send_set($urandom_range(2, 8));
        wait_drained();
    endtask

    // receiver: random stall bursts, long hold when requested, none at the end
    initial begin
        int burst;
        burst = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready = 1'b0;
                hold_cycles--;
            end else if (burst > 0) begin
                m_tready = 1'b0;
                burst--;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                burst = $urandom_range(0, 3);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        env_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (envelope_due.size() == 0) begin
                errors++;
                $display("%0t unexpected envelope word %h", $time, m_tdata);
            end else begin
                w = envelope_due.pop_front();
                if (m_tdata[31:0] !== w.slope || m_tdata[63:32] !== w.offset ||
                    m_tdata[79:64] !== w.tag || m_tdata[127:80] !== w.bound ||
                    m_tuser[0] !== w.unb || m_tuser[1] !== w.dropped ||
                    m_tlast !== w.lst) begin
                    errors++;
                    $display("%0t mismatch exp s=%h o=%h t=%h b=%h unb=%b drp=%b last=%b",
                             $time, w.slope, w.offset, w.tag, w.bound, w.unb, w.dropped,
                             w.lst);
                    $display("%0t          got s=%h o=%h t=%h b=%h unb=%b drp=%b last=%b",
                             $time, m_tdata[31:0], m_tdata[63:32], m_tdata[79:64],
                             m_tdata[127:80], m_tuser[0], m_tuser[1], m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit) begin
            $display("%0t watchdog: no word moved, %0d envelope words outstanding", $time,
                     envelope_due.size());
            $display("line_upper_envelope_sweep verification failed");
            $finish;
        end
    end

    initial begin
        errors = 0; lines_sent = 0; sets_swept = 0; words_seen = 0; overflow_sets = 0;
        idle_cycles = 0; hold_cycles = 0; quiet = 0; set_overflow = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_overflow();
        test_backpressure();
        test_random();
        test_no_idle();
        repeat (50) @(posedge aclk);
        $display("covered %0d lines in %0d sets (%0d over capacity), %0d envelope words",
                 lines_sent, sets_swept, overflow_sets, words_seen);
        if (errors == 0 && envelope_due.size() == 0) begin
            $display("line_upper_envelope_sweep verification clean");
        end else begin
            $display("%0d mismatches, %0d words never arrived", errors, envelope_due.size());
            $display("line_upper_envelope_sweep verification failed");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/lues_pkg.sv
rtl/lues_div.sv
rtl/line_upper_envelope_sweep.sv
dv/tb_top.sv
